@@ rtl/core/hgsm_pkg.sv @@
// Shared constants, codes and types for the histogram greedy size matcher.
`timescale 1ns / 1ps

package hgsm_pkg;

   localparam int SIZE_LEVELS = 128;
   localparam int MAX_ITEMS   = 4096;

   localparam int ADDR_W  = $clog2(SIZE_LEVELS);
   localparam int HIST_W  = 13;
   localparam int TOTAL_W = $clog2(MAX_ITEMS + 1);
   localparam int SIZE_W  = 8;
   localparam int OP_W    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_SUPPLY = 2'd0,
      OP_DEMAND = 2'd1,
      OP_FINISH = 2'd2
   } hgsm_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_FLUSH,
      ST_EMIT
   } hgsm_state_type;

   typedef struct packed {
      logic start;
      logic vld;
   } hgsm_sweep_ctl_type;

endpackage

@@ rtl/core/hgsm_sweep.sv @@
// Sweep accumulator: carries unserved demands across sizes and counts matches.
`timescale 1ns / 1ps

module hgsm_sweep
   import hgsm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  hgsm_sweep_ctl_type ctl,
   input  logic [HIST_W-1:0]  supply_cnt,
   input  logic [HIST_W-1:0]  demand_cnt,
   output logic [HIST_W-1:0]  matched
);

   logic [HIST_W-1:0] waiting_ff, waiting_in;
   logic [HIST_W-1:0] matched_ff, matched_in;
   logic [HIST_W-1:0] pend;
   logic [HIST_W-1:0] served;

   always_comb begin
      pend       = waiting_ff + demand_cnt;
      served     = (supply_cnt < pend) ? supply_cnt : pend;
      waiting_in = waiting_ff;
      matched_in = matched_ff;
      if (ctl.start) begin
         waiting_in = '0;
         matched_in = '0;
      end else if (ctl.vld) begin
         waiting_in = pend - served;
         matched_in = matched_ff + served;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff <= '0;
         matched_ff <= '0;
      end else begin
         waiting_ff <= waiting_in;
         matched_ff <= matched_in;
      end
   end

   assign matched = matched_ff;

endmodule

@@ rtl/core/histogram_greedy_size_matcher.sv @@
// A load reads its histogram row as it is accepted and writes the incremented
// count back in the cycle after; one load per cycle while the input is open.
// A finish closes the input for a sweep that reads one histogram row per cycle
// through the memory read port, and the result is presented as it reopens;
// it stays closed longer while an earlier result is still waiting on rsp_tready.
// Reset: synchronous; a clearing pass over every row zeroes both
// histogram memories before the first item is accepted.
`timescale 1ns / 1ps

module histogram_greedy_size_matcher
   import hgsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] size_value
   input  logic [1:0]  req_tuser,  // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [12:0] match_count, [15:13] zero
   output logic [0:0]  rsp_tuser   // [0] dropped
);

   localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(SIZE_LEVELS - 1);
   localparam logic [SIZE_W:0]    LEVELS_X  = (SIZE_W + 1)'(SIZE_LEVELS);
   localparam logic [TOTAL_W-1:0] MAX_TOT   = TOTAL_W'(MAX_ITEMS);

   hgsm_state_type state_ff, state_in;

   logic [HIST_W-1:0] sup_mem [SIZE_LEVELS];
   logic [HIST_W-1:0] dem_mem [SIZE_LEVELS];

   logic [HIST_W-1:0] sup_rd_ff, dem_rd_ff;
   logic [ADDR_W-1:0] rd_addr;

   logic [ADDR_W-1:0] k_ff, k_in;
   logic              k_run;

   logic              ld_vld_ff, ld_vld_in;
   logic              ld_sel_ff;        // 0 supply, 1 demand
   logic [ADDR_W-1:0] ld_addr_ff;
   logic              ld_fwd_ff, ld_fwd_in;
   logic [HIST_W-1:0] last_wr_ff;
   logic [HIST_W-1:0] ld_new;

   logic              sw_vld_ff;
   logic [ADDR_W-1:0] sw_addr_ff;

   logic [TOTAL_W-1:0] sup_total_ff, sup_total_in;
   logic [TOTAL_W-1:0] dem_total_ff, dem_total_in;
   logic               drop_flag_ff, drop_flag_in;
   logic               fin_drop_ff;

   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [HIST_W-1:0]  rsp_count_ff;
   logic               rsp_drop_ff;
   logic               emit_load;

   logic               req_fire;
   hgsm_op_type        op;
   logic [SIZE_W-1:0]  size_v;
   logic               in_range;
   logic               is_sup, is_dem, is_fin;
   logic               sup_ok, dem_ok;
   logic [ADDR_W-1:0]  load_addr;

   logic               sup_we, dem_we;
   logic [ADDR_W-1:0]  wr_addr;
   logic [HIST_W-1:0]  wr_data;

   hgsm_sweep_ctl_type sweep_ctl;
   logic [HIST_W-1:0]  matched;

   // ---------------- input decode ----------------
   assign req_fire  = req_tvalid && req_tready;
   assign op        = hgsm_op_type'(req_tuser);
   assign size_v    = req_tdata;
   assign in_range  = (size_v != '0) && ({1'b0, size_v} <= LEVELS_X);
   assign load_addr = ADDR_W'(size_v - SIZE_W'(1));
   assign is_sup    = req_fire && (op == OP_SUPPLY);
   assign is_dem    = req_fire && (op == OP_DEMAND);
   assign is_fin    = req_fire && (op == OP_FINISH);
   assign sup_ok    = is_sup && in_range && (sup_total_ff < MAX_TOT);
   assign dem_ok    = is_dem && in_range && (dem_total_ff < MAX_TOT);

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (k_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (is_fin) state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (k_ff == LAST_ADDR) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      k_run      = 1'b0;
      emit_load  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            k_run = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_SWEEP: begin
            k_run = 1'b1;
         end
         ST_FLUSH: begin
         end
         ST_EMIT: begin
            emit_load = !rsp_tvalid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   assign k_in = !k_run ? k_ff : ((k_ff == LAST_ADDR) ? '0 : k_ff + ADDR_W'(1));

   // ---------------- load read-modify-write ----------------
   // A load to the same row as the one still in write-back takes the
   // value being written instead of the stale read.
   assign ld_vld_in = sup_ok || dem_ok;
   assign ld_fwd_in = ld_vld_ff && (ld_sel_ff == dem_ok) && (ld_addr_ff == load_addr);
   assign ld_new    = (ld_fwd_ff ? last_wr_ff : (ld_sel_ff ? dem_rd_ff : sup_rd_ff))
                      + HIST_W'(1);

   assign rd_addr = (state_ff == ST_SWEEP) ? k_ff : load_addr;

   always_comb begin
      sup_we  = 1'b0;
      dem_we  = 1'b0;
      wr_addr = ld_addr_ff;
      wr_data = ld_new;
      if (state_ff == ST_CLEAR) begin
         sup_we  = 1'b1;
         dem_we  = 1'b1;
         wr_addr = k_ff;
         wr_data = '0;
      end else if (sw_vld_ff) begin
         // rows are zeroed as the sweep passes over them
         sup_we  = 1'b1;
         dem_we  = 1'b1;
         wr_addr = sw_addr_ff;
         wr_data = '0;
      end else if (ld_vld_ff) begin
         sup_we = !ld_sel_ff;
         dem_we = ld_sel_ff;
      end
   end

   always_ff @(posedge clock) begin
      sup_rd_ff <= sup_mem[rd_addr];
      if (sup_we) begin
         sup_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      dem_rd_ff <= dem_mem[rd_addr];
      if (dem_we) begin
         dem_mem[wr_addr] <= wr_data;
      end
   end

   // ---------------- totals and drop flag ----------------
   always_comb begin
      sup_total_in = sup_total_ff;
      dem_total_in = dem_total_ff;
      drop_flag_in = drop_flag_ff;
      if (is_fin) begin
         sup_total_in = '0;
         dem_total_in = '0;
         drop_flag_in = 1'b0;
      end else begin
         if (sup_ok) sup_total_in = sup_total_ff + TOTAL_W'(1);
         if (dem_ok) dem_total_in = dem_total_ff + TOTAL_W'(1);
         if ((is_sup && !sup_ok) || (is_dem && !dem_ok)) drop_flag_in = 1'b1;
      end
   end

   // ---------------- sweep ----------------
   assign sweep_ctl.start = is_fin;
   assign sweep_ctl.vld   = sw_vld_ff;

   hgsm_sweep u_sweep (
      .clock      (clock),
      .reset      (reset),
      .ctl        (sweep_ctl),
      .supply_cnt (sup_rd_ff),
      .demand_cnt (dem_rd_ff),
      .matched    (matched)
   );

   // ---------------- result register ----------------
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (emit_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         k_ff          <= '0;
         ld_vld_ff     <= 1'b0;
         sw_vld_ff     <= 1'b0;
         sup_total_ff  <= '0;
         dem_total_ff  <= '0;
         drop_flag_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         k_ff          <= k_in;
         ld_vld_ff     <= ld_vld_in;
         sw_vld_ff     <= (state_ff == ST_SWEEP);
         sup_total_ff  <= sup_total_in;
         dem_total_ff  <= dem_total_in;
         drop_flag_ff  <= drop_flag_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      ld_sel_ff  <= dem_ok;
      ld_addr_ff <= load_addr;
      ld_fwd_ff  <= ld_fwd_in;
      last_wr_ff <= ld_new;
      sw_addr_ff <= k_ff;
      if (is_fin) begin
         fin_drop_ff <= drop_flag_ff;
      end
      if (emit_load) begin
         rsp_count_ff <= matched;
         rsp_drop_ff  <= fin_drop_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(16 - HIST_W)'(0), rsp_count_ff};
   assign rsp_tuser  = rsp_drop_ff;

endmodule

@@ rtl/core/hgsm_checker.sv @@
// Port-level checker for the histogram greedy size matcher, with its bind.
`timescale 1ns / 1ps

module hgsm_checker
   import hgsm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // result held, unchanged, until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result dropped or changed while stalled");

   // clearing pass keeps the input closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("input open during clearing pass");

   // a new result only appears after the sweep held the input closed
   a_rsp_after_sweep: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result without a sweep");

   // a match count never exceeds what one multiset can hold
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata <= 16'(MAX_ITEMS)))
      else $error("match count out of range");

endmodule

bind histogram_greedy_size_matcher hgsm_checker u_hgsm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
